// File: hw/rtl/tsat_pkg.sv
// ----------------------------------------------------------------------------
// tsat_pkg
// Shared types and constants for the slot assignment table.
// ----------------------------------------------------------------------------
package tsat_pkg;

  localparam int DEV_W      = 8;
  localparam int TIME_W     = 32;
  localparam int GRID_W     = 5;
  localparam int TMO_W      = 20;
  localparam int SLOT_CNT_W = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam logic [DEV_W-1:0] REFUSED_SLOT = 8'hFF;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_CHANNEL    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MS      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BROADCAST_INDEX = 2'd2;

  localparam logic [GRID_W-1:0]  GRID_RESET      = 5'd0;
  localparam logic [TMO_W-1:0]   TIMEOUT_RESET   = 20'd5000;
  localparam logic [DEV_W-1:0]   BROADCAST_RESET = 8'd255;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_EXPIRE,
    ST_RESLOT,
    ST_EMIT,
    ST_REFUSE
  } state_t;

  typedef struct packed {
    logic load;
    logic next;
    logic touch;
    logic append;
    logic keep;
    logic drop;
    logic commit;
    logic reslot;
    logic emit_entry;
    logic emit_refuse;
  } cmd_t;

  typedef struct packed {
    logic bcast;
    logic join_req;
    logic at_end;
    logic hit;
    logic expired;
    logic changed;
    logic full;
    logic empty;
    logic last_entry;
    logic out_free;
  } sts_t;

endpackage

// File: hw/rtl/tsat_ctrl.sv
// ----------------------------------------------------------------------------
// tsat_ctrl
// Sequencer for lookup, expiry compaction, reslot and result emission.
// ----------------------------------------------------------------------------
module tsat_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            func,
  input  tsat_pkg::sts_t  sts,
  output tsat_pkg::cmd_t  cmd,
  output logic            in_stall
);

  tsat_pkg::state_t state;
  tsat_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tsat_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = (state != tsat_pkg::ST_IDLE);
    unique case (state)
      tsat_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = func ? tsat_pkg::ST_EXPIRE : tsat_pkg::ST_LOOKUP;
        end
      end
      tsat_pkg::ST_LOOKUP: begin
        priority if (sts.bcast) begin
          state_next = tsat_pkg::ST_IDLE;
        end else if (sts.at_end) begin
          priority if (!sts.join_req) begin
            state_next = tsat_pkg::ST_IDLE;
          end else if (sts.full) begin
            state_next = tsat_pkg::ST_REFUSE;
          end else begin
            cmd.append = 1'b1;
            state_next = tsat_pkg::ST_RESLOT;
          end
        end else if (sts.hit) begin
          cmd.touch  = 1'b1;
          state_next = tsat_pkg::ST_IDLE;
        end else begin
          cmd.next = 1'b1;
        end
      end
      tsat_pkg::ST_EXPIRE: begin
        priority if (sts.at_end) begin
          if (sts.changed) begin
            cmd.commit = 1'b1;
            state_next = tsat_pkg::ST_RESLOT;
          end else begin
            state_next = tsat_pkg::ST_IDLE;
          end
        end else if (sts.expired) begin
          cmd.drop = 1'b1;
        end else begin
          cmd.keep = 1'b1;
        end
      end
      tsat_pkg::ST_RESLOT: begin
        cmd.reslot = 1'b1;
        state_next = sts.empty ? tsat_pkg::ST_IDLE : tsat_pkg::ST_EMIT;
      end
      tsat_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_entry = 1'b1;
          if (sts.last_entry) begin
            state_next = tsat_pkg::ST_IDLE;
          end
        end
      end
      tsat_pkg::ST_REFUSE: begin
        if (sts.out_free) begin
          cmd.emit_refuse = 1'b1;
          state_next      = tsat_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tsat_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/tsat_datapath.sv
// ----------------------------------------------------------------------------
// tsat_datapath
// Device table, configuration registers, scan counters and result register.
// ----------------------------------------------------------------------------
module tsat_datapath #(
  parameter int MAX_DEVICES = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [tsat_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tsat_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [tsat_pkg::DEV_W-1:0]         dev_index,
  input  logic                               is_join,
  input  logic [tsat_pkg::TIME_W-1:0]        now_ms,
  input  tsat_pkg::cmd_t                     cmd,
  output tsat_pkg::sts_t                     sts,
  input  logic                               out_stall,
  output logic                               out_valid,
  output logic [tsat_pkg::DEV_W-1:0]         dest_index,
  output logic [tsat_pkg::GRID_W-1:0]        grid_out,
  output logic [tsat_pkg::DEV_W-1:0]         assigned_slot,
  output logic [tsat_pkg::SLOT_CNT_W-1:0]    slot_count,
  output logic [tsat_pkg::DEV_W-1:0]         map_version,
  output logic                               last
);

  localparam int CNT_W = $clog2(MAX_DEVICES + 1);
  localparam int IDX_W = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_DEVICES);

  logic [tsat_pkg::GRID_W-1:0] grid_channel;
  logic [tsat_pkg::TMO_W-1:0]  timeout_ms;
  logic [tsat_pkg::DEV_W-1:0]  broadcast_index;

  logic [tsat_pkg::DEV_W-1:0]  entry_index     [MAX_DEVICES];
  logic [tsat_pkg::TIME_W-1:0] entry_last_seen [MAX_DEVICES];
  logic [CNT_W-1:0]            entry_count;
  logic [tsat_pkg::DEV_W-1:0]  map_ver;
  logic [CNT_W-1:0]            slot_total;

  logic [tsat_pkg::DEV_W-1:0]  item_dev;
  logic                        item_join;
  logic [tsat_pkg::TIME_W-1:0] item_now;
  logic [CNT_W-1:0]            scan;
  logic [CNT_W-1:0]            wr_pos;
  logic                        changed;

  logic                        at_end;
  logic [IDX_W-1:0]            rd_idx;
  logic [tsat_pkg::DEV_W-1:0]  rd_dev;
  logic [tsat_pkg::TIME_W-1:0] rd_seen;
  logic [tsat_pkg::TIME_W-1:0] silence;
  logic                        out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_channel    <= tsat_pkg::GRID_RESET;
      timeout_ms      <= tsat_pkg::TIMEOUT_RESET;
      broadcast_index <= tsat_pkg::BROADCAST_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tsat_pkg::REG_GRID_CHANNEL:    grid_channel    <= cfg_data[tsat_pkg::GRID_W-1:0];
        tsat_pkg::REG_TIMEOUT_MS:      timeout_ms      <= cfg_data[tsat_pkg::TMO_W-1:0];
        tsat_pkg::REG_BROADCAST_INDEX: broadcast_index <= cfg_data[tsat_pkg::DEV_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign at_end   = (scan == entry_count);
  assign rd_idx   = at_end ? '0 : scan[IDX_W-1:0];
  assign rd_dev   = entry_index[rd_idx];
  assign rd_seen  = entry_last_seen[rd_idx];
  assign silence  = item_now - rd_seen;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    sts            = '0;
    sts.bcast      = (item_dev == broadcast_index);
    sts.join_req   = item_join;
    sts.at_end     = at_end;
    sts.hit        = (rd_dev == item_dev);
    sts.expired    = (silence > tsat_pkg::TIME_W'(timeout_ms));
    sts.changed    = changed;
    sts.full       = (entry_count == MAX_CNT);
    sts.empty      = (entry_count == '0);
    sts.last_entry = ((scan + CNT_W'(1)) == entry_count);
    sts.out_free   = out_free;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_dev  <= dev_index;
      item_join <= is_join;
      item_now  <= now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.touch) begin
      entry_last_seen[scan[IDX_W-1:0]] <= item_now;
    end else if (cmd.append) begin
      entry_index[entry_count[IDX_W-1:0]]     <= item_dev;
      entry_last_seen[entry_count[IDX_W-1:0]] <= item_now;
    end else if (cmd.keep) begin
      entry_index[wr_pos[IDX_W-1:0]]     <= rd_dev;
      entry_last_seen[wr_pos[IDX_W-1:0]] <= rd_seen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      map_ver     <= '0;
      slot_total  <= CNT_W'(1);
      scan        <= '0;
      wr_pos      <= '0;
      changed     <= 1'b0;
    end else begin
      if (cmd.load) begin
        scan    <= '0;
        wr_pos  <= '0;
        changed <= 1'b0;
      end
      if (cmd.next || cmd.drop || cmd.keep || cmd.emit_entry) begin
        scan <= scan + CNT_W'(1);
      end
      if (cmd.keep) begin
        wr_pos <= wr_pos + CNT_W'(1);
      end
      if (cmd.drop) begin
        changed <= 1'b1;
      end
      if (cmd.append) begin
        entry_count <= entry_count + CNT_W'(1);
      end
      if (cmd.commit) begin
        entry_count <= wr_pos;
      end
      if (cmd.reslot) begin
        map_ver    <= map_ver + 8'd1;
        slot_total <= (entry_count == '0) ? CNT_W'(1) : entry_count;
        scan       <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_entry || cmd.emit_refuse) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_entry || cmd.emit_refuse) begin
      grid_out    <= grid_channel;
      slot_count  <= tsat_pkg::SLOT_CNT_W'(slot_total);
      map_version <= map_ver;
    end
    if (cmd.emit_entry) begin
      dest_index    <= rd_dev;
      assigned_slot <= tsat_pkg::DEV_W'(scan);
      last          <= sts.last_entry;
    end else if (cmd.emit_refuse) begin
      dest_index    <= item_dev;
      assigned_slot <= tsat_pkg::REFUSED_SLOT;
      last          <= 1'b1;
    end
  end

endmodule

// File: hw/rtl/tdma_slot_assignment_table_top.sv
// ----------------------------------------------------------------------------
// tdma_slot_assignment_table_top
// Gateway device table with TDMA slot assignment and expiry.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) takes one word per event: an uplink
// frame seen (func 0) or an expire tick (func 1). The output channel
// (out_valid/out_stall) gives assign words, one per table entry in slot
// order with last set on the final one, or one refusal word (slot 255)
// when a join finds the table full. Configuration is written through
// cfg_we/cfg_index/cfg_data, by the user only while the block is idle;
// the block itself does not enforce this. An uplink is looked up by a
// serial scan over the entries; a join that is appended then reslots
// and emits one word per entry. An expire tick scans all entries and
// drops expired ones; if any was dropped, it reslots and emits the rest.
// The single-ported table is scanned serially; one event is in work
// at a time. The output register lets the next word be taken while a
// result still waits; a stall on the output holds the emit sequence.
// Reset empties the table, clears the map version, sets the slot count
// to one and loads the register defaults; it needs no clearing pass.
// ----------------------------------------------------------------------------
module tdma_slot_assignment_table_top #(
  parameter int MAX_DEVICES = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [tsat_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tsat_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               func,
  input  logic [tsat_pkg::DEV_W-1:0]         dev_index,
  input  logic                               is_join,
  input  logic [tsat_pkg::TIME_W-1:0]        now_ms,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [tsat_pkg::DEV_W-1:0]         dest_index,
  output logic [tsat_pkg::GRID_W-1:0]        grid_out,
  output logic [tsat_pkg::DEV_W-1:0]         assigned_slot,
  output logic [tsat_pkg::SLOT_CNT_W-1:0]    slot_count,
  output logic [tsat_pkg::DEV_W-1:0]         map_version,
  output logic                               last
);

  tsat_pkg::cmd_t cmd;
  tsat_pkg::sts_t sts;

  tsat_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .func     (func),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  tsat_datapath #(
    .MAX_DEVICES (MAX_DEVICES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .dev_index     (dev_index),
    .is_join       (is_join),
    .now_ms        (now_ms),
    .cmd           (cmd),
    .sts           (sts),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .dest_index    (dest_index),
    .grid_out      (grid_out),
    .assigned_slot (assigned_slot),
    .slot_count    (slot_count),
    .map_version   (map_version),
    .last          (last)
  );

endmodule

// File: hw/rtl/tsat_checker.sv
// ----------------------------------------------------------------------------
// tsat_checker
// Port-level checks for the slot assignment table, bound to the top level.
// ----------------------------------------------------------------------------
module tsat_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [tsat_pkg::DEV_W-1:0]      assigned_slot,
  input logic [tsat_pkg::SLOT_CNT_W-1:0] slot_count,
  input logic                            last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output word dropped while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

  a_refuse_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (assigned_slot == tsat_pkg::REFUSED_SLOT) |-> last)
    else $error("refusal word not flagged last");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && (assigned_slot != tsat_pkg::REFUSED_SLOT)
      |-> (assigned_slot < tsat_pkg::DEV_W'(slot_count)))
    else $error("assigned slot beyond slot count");

  a_last_at_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && last && (assigned_slot != tsat_pkg::REFUSED_SLOT)
      |-> (tsat_pkg::DEV_W'(slot_count) == assigned_slot + 8'd1))
    else $error("last word is not the final slot");

endmodule

bind tdma_slot_assignment_table_top tsat_checker u_tsat_checker (
  .clk           (clk),
  .rst           (rst),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .assigned_slot (assigned_slot),
  .slot_count    (slot_count),
  .last          (last)
);
